// ----- rtl/mmfm_pkg.sv -----
package mmfm_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam int unsigned FRAME_BITS   = 32;
	localparam int unsigned MAX_PREAMBLE = 32;
	localparam int unsigned POS_W        = 7;
	localparam int unsigned PRE_W        = 6;
	localparam int unsigned DATA_W       = 16;
	localparam int unsigned ADDR_W       = 5;
	localparam int unsigned PADDR_W      = 3;
	localparam int unsigned PDATA_W      = 32;

	localparam logic [PADDR_W-1:0] REG_PREAMBLE_LENGTH = 3'd0;

	localparam logic [1:0] START_CODE   = 2'b01;
	localparam logic [1:0] OP_READ      = 2'b10;
	localparam logic [1:0] OP_WRITE     = 2'b01;
	localparam logic [1:0] TA_WRITE     = 2'b10;
	localparam logic [POS_W-1:0] TA_END = 7'd18;

endpackage

// ----- rtl/mdio_management_frame_master_core.sv -----
// Clause-22 MDIO frame master, one MDC period per tick transfer.
// A tick result appears in the output register in the cycle after its transfer.
// Throughput: one input transfer per cycle; the output register holds one result and
// stalls the input only while that result is not taken.
// Reset: arst_n clears the frame state, the output valid flag and preamble_length to zero.
module mdio_management_frame_master_core
	import mmfm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [ADDR_W-1:0]   phy_addr,
	input  logic [ADDR_W-1:0]   reg_addr,
	input  logic [DATA_W-1:0]   write_data,
	input  logic                mdi,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                mdo,
	output logic                mdo_enable,
	output logic                frame_active,
	output logic                done_res,
	output logic [DATA_W-1:0]   read_data
);

	logic [PRE_W-1:0]      preamble_length_q;
	logic                  busy_q;
	logic                  is_read_q;
	logic [POS_W-1:0]      bit_position_q;
	logic [FRAME_BITS-1:0] frame_shift_q;
	logic [DATA_W-1:0]     read_shift_q;

	logic                  out_valid_q;
	logic                  mdo_q;
	logic                  mdo_enable_q;
	logic                  frame_active_q;
	logic                  done_q;
	logic [DATA_W-1:0]     read_data_q;

	cmd_t                  cmd_c;
	logic                  accept;
	logic                  cfg_write;
	logic                  start;
	logic                  tick;
	logic [PRE_W-1:0]      pre_c;
	logic [FRAME_BITS-1:0] frame_c;
	logic                  mdo_c;
	logic                  en_c;
	logic                  done_c;
	logic                  shift_in_c;
	logic [DATA_W-1:0]     read_shift_c;
	logic [DATA_W-1:0]     rd_c;

	assign pready    = 1'b1;
	assign prdata    = {{(PDATA_W-PRE_W){1'b0}}, preamble_length_q};
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PREAMBLE_LENGTH[2]);

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cmd_c     = cmd_t'(cmd);

	always_comb begin
		start = 1'b0;
		tick  = 1'b0;
		case (cmd_c)
			CMD_TICK: begin
				tick = accept;
			end
			CMD_READ, CMD_WRITE: begin
				start = accept && !busy_q;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	always_comb begin
		pre_c = (preamble_length_q > PRE_W'(MAX_PREAMBLE)) ? PRE_W'(MAX_PREAMBLE)
			: preamble_length_q;
		frame_c          = '0;
		frame_c[31:30]   = START_CODE;
		frame_c[29:28]   = (cmd_c == CMD_READ) ? OP_READ : OP_WRITE;
		frame_c[27:23]   = phy_addr;
		frame_c[22:18]   = reg_addr;
		if (cmd_c == CMD_WRITE) begin
			frame_c[17:16] = TA_WRITE;
			frame_c[15:0]  = write_data;
		end
	end

	always_comb begin
		mdo_c        = 1'b0;
		en_c         = 1'b0;
		shift_in_c   = 1'b0;
		done_c       = 1'b0;
		if (bit_position_q >= POS_W'(FRAME_BITS)) begin
			mdo_c = 1'b1;
			en_c  = 1'b1;
		end else if (is_read_q && (bit_position_q < TA_END)) begin
			shift_in_c = (bit_position_q < POS_W'(DATA_W));
		end else begin
			mdo_c = frame_shift_q[bit_position_q[4:0]];
			en_c  = 1'b1;
		end
		done_c       = (bit_position_q == '0);
		read_shift_c = shift_in_c ? {read_shift_q[DATA_W-2:0], mdi} : read_shift_q;
		rd_c         = (done_c && is_read_q) ? read_shift_c : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_length_q <= '0;
		end else if (cfg_write) begin
			preamble_length_q <= pwdata[PRE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			is_read_q      <= 1'b0;
			bit_position_q <= '0;
			frame_shift_q  <= '0;
			read_shift_q   <= '0;
		end else if (start) begin
			busy_q         <= 1'b1;
			is_read_q      <= (cmd_c == CMD_READ);
			bit_position_q <= POS_W'(pre_c) + POS_W'(FRAME_BITS - 1);
			frame_shift_q  <= frame_c;
			read_shift_q   <= '0;
		end else if (tick && busy_q) begin
			read_shift_q <= read_shift_c;
			if (done_c) begin
				busy_q <= 1'b0;
			end else begin
				bit_position_q <= bit_position_q - POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			mdo_q          <= busy_q && mdo_c;
			mdo_enable_q   <= busy_q && en_c;
			frame_active_q <= busy_q;
			done_q         <= busy_q && done_c;
			read_data_q    <= busy_q ? rd_c : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign mdo          = mdo_q;
	assign mdo_enable   = mdo_enable_q;
	assign frame_active = frame_active_q;
	assign done_res     = done_q;
	assign read_data    = read_data_q;

endmodule
